// ----- design/kthsel_pkg.sv -----
package kthsel_pkg;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // Microprogram step addresses
  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_PIV_RD   = 4'd1,
    S_PIV_LD   = 4'd2,
    S_SCAN_RD  = 4'd3,
    S_SCAN_CMP = 4'd4,
    S_SWAP_A   = 4'd5,
    S_SWAP_B   = 4'd6,
    S_ADV      = 4'd7,
    S_FIN_RD   = 4'd8,
    S_FIN_A    = 4'd9,
    S_FIN_B    = 4'd10,
    S_NARROW   = 4'd11
  } step_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_LESS,
    C_I_GT_HI,
    C_I_LT_HI,
    C_FOUND
  } cond_e;

  typedef enum logic {RDA_LO, RDA_I} rda_sel_e;
  typedef enum logic {RDB_SLOT_NXT, RDB_SLOT} rdb_sel_e;
  typedef enum logic [1:0] {WA_SLOT_NXT, WA_I, WA_LO, WA_SLOT} wa_sel_e;
  typedef enum logic [1:0] {WD_RD_A, WD_RD_B, WD_PIVOT} wd_sel_e;

  typedef struct packed {
    logic     rd_en;
    rda_sel_e rda_sel;
    rdb_sel_e rdb_sel;
    logic     wr_en;
    wa_sel_e  wa_sel;
    wd_sel_e  wd_sel;
    logic     init;      // slot <= lo, i <= lo + 1
    logic     piv_ld;
    logic     slot_inc;
    logic     i_inc;
    logic     narrow;
    logic     res;       // emit result when the jump is taken
    cond_e    cond;
    step_e    tgt;
  } ctl_t;

  // Control store: one word per step, jump to tgt when cond holds, else fall through
  function automatic ctl_t ucode(step_e s);
    ctl_t c;
    c = '0;
    case (s)
      S_IDLE: begin
        c.cond = C_ALWAYS;
        c.tgt  = S_IDLE;
      end
      S_PIV_RD: begin
        c.rd_en   = 1'b1;
        c.rda_sel = RDA_LO;
        c.init    = 1'b1;
      end
      S_PIV_LD: begin
        c.piv_ld = 1'b1;
        c.cond   = C_I_GT_HI;
        c.tgt    = S_FIN_RD;
      end
      S_SCAN_RD: begin
        c.rd_en   = 1'b1;
        c.rda_sel = RDA_I;
        c.rdb_sel = RDB_SLOT_NXT;
      end
      S_SCAN_CMP: begin
        c.cond = C_NOT_LESS;
        c.tgt  = S_ADV;
      end
      S_SWAP_A: begin
        c.wr_en    = 1'b1;
        c.wa_sel   = WA_SLOT_NXT;
        c.wd_sel   = WD_RD_A;
        c.slot_inc = 1'b1;
      end
      S_SWAP_B: begin
        c.wr_en  = 1'b1;
        c.wa_sel = WA_I;
        c.wd_sel = WD_RD_B;
      end
      S_ADV: begin
        c.i_inc = 1'b1;
        c.cond  = C_I_LT_HI;
        c.tgt   = S_SCAN_RD;
      end
      S_FIN_RD: begin
        c.rd_en   = 1'b1;
        c.rdb_sel = RDB_SLOT;
      end
      S_FIN_A: begin
        c.wr_en  = 1'b1;
        c.wa_sel = WA_LO;
        c.wd_sel = WD_RD_B;
      end
      S_FIN_B: begin
        c.wr_en  = 1'b1;
        c.wa_sel = WA_SLOT;
        c.wd_sel = WD_PIVOT;
        c.res    = 1'b1;
        c.cond   = C_FOUND;
        c.tgt    = S_IDLE;
      end
      S_NARROW: begin
        c.narrow = 1'b1;
        c.cond   = C_ALWAYS;
        c.tgt    = S_PIV_RD;
      end
      default: begin
        c.cond = C_ALWAYS;
        c.tgt  = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- design/kth_smallest_quickselect.sv -----
// Load requests: one per cycle while idle, no result, busy stays low.
// Select requests: invalid bounds give done_o with range_error_o the cycle after accept.
// A valid select runs quickselect in the microcode sequencer: each partition round reads the pivot,
// scans every element against it, swaps those below it down, places the pivot, then ends or narrows.
// The receiver cannot stall; done_o is a single-cycle strobe.
// rst_ni (async, active low) clears the load count, the sequencer and the strobe; the store is not cleared.
module kth_smallest_quickselect #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               operation_i,
  input  logic signed [31:0] value_i,
  input  logic        [9:0]  left_index_i,
  input  logic        [9:0]  right_index_i,
  input  logic        [10:0] rank_i,
  output logic               done_o,
  output logic signed [31:0] selected_value_o,
  output logic               range_error_o
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = AW + 1;              // index regs reach one past the last slot
  localparam int XW = (CW > 11) ? CW : 11; // width for request bound checks

  // element store, two registered read ports, one write port
  logic signed [31:0] mem_q [MAX_ELEMENTS];
  logic signed [31:0] rd_a_q, rd_b_q;

  // sequencer state
  kthsel_pkg::step_e step_q, step_d;
  kthsel_pkg::ctl_t  ctl;
  logic              cond_hit;

  // datapath registers
  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d, tgt_q, tgt_d;
  logic [IW-1:0] slot_q, slot_d, i_q, i_d, slot_nxt;
  logic signed [31:0] pivot_q, pivot_d;

  // load bookkeeping
  logic [CW-1:0] count_q, count_d, eff_cnt;
  logic          restart_q, restart_d, room;

  // result register
  logic               done_d, err_d;
  logic signed [31:0] res_d;

  // request decode
  logic          accept, is_load, is_sel, bad_req;
  logic [XW-1:0] left_x, right_x, rank_x, rank_m1, cnt_x;
  logic          less, found;

  // memory port controls
  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic signed [31:0] wdata;

  assign busy    = (step_q != kthsel_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign is_load = accept && (operation_i == kthsel_pkg::OP_LOAD);
  assign is_sel  = accept && (operation_i == kthsel_pkg::OP_SELECT);

  assign left_x  = XW'(left_index_i);
  assign right_x = XW'(right_index_i);
  assign rank_x  = XW'(rank_i);
  assign rank_m1 = rank_x - XW'(1);
  assign cnt_x   = XW'(count_q);
  // rank == 0 wraps rank_m1 to all ones, which also trips the upper bound check
  assign bad_req = (left_x > right_x) || (right_x >= cnt_x) || (rank_x == '0) ||
                   (rank_m1 < left_x) || (rank_m1 > right_x);

  // a select arms restart: the next load begins a fresh array at slot 0
  assign eff_cnt = restart_q ? '0 : count_q;
  assign room    = (eff_cnt < CW'(MAX_ELEMENTS));

  assign ctl      = kthsel_pkg::ucode(step_q);
  assign slot_nxt = slot_q + IW'(1);
  assign less     = (rd_a_q < pivot_q);
  assign found    = (lo_q == hi_q) || (slot_q == tgt_q);

  always_comb begin
    case (ctl.cond)
      kthsel_pkg::C_NEVER:    cond_hit = 1'b0;
      kthsel_pkg::C_ALWAYS:   cond_hit = 1'b1;
      kthsel_pkg::C_NOT_LESS: cond_hit = !less;
      kthsel_pkg::C_I_GT_HI:  cond_hit = (i_q > hi_q);
      kthsel_pkg::C_I_LT_HI:  cond_hit = (i_q < hi_q);
      kthsel_pkg::C_FOUND:    cond_hit = found;
      default:                cond_hit = 1'b0;
    endcase
  end

  // sequencer, datapath updates and result
  always_comb begin
    step_d    = cond_hit ? ctl.tgt : kthsel_pkg::step_e'(step_q + 4'd1);
    lo_d      = lo_q;
    hi_d      = hi_q;
    tgt_d     = tgt_q;
    slot_d    = slot_q;
    i_d       = i_q;
    pivot_d   = pivot_q;
    count_d   = count_q;
    restart_d = restart_q;
    done_d    = 1'b0;
    err_d     = 1'b0;
    res_d     = '0;

    if (step_q == kthsel_pkg::S_IDLE) begin
      step_d = kthsel_pkg::S_IDLE;
      if (is_load) begin
        restart_d = 1'b0;
        count_d   = room ? (eff_cnt + CW'(1)) : eff_cnt;
      end
      if (is_sel) begin
        restart_d = 1'b1;
        if (bad_req) begin
          done_d = 1'b1;
          err_d  = 1'b1;
        end else begin
          lo_d   = IW'(left_index_i);
          hi_d   = IW'(right_index_i);
          tgt_d  = IW'(rank_m1);
          step_d = kthsel_pkg::S_PIV_RD;
        end
      end
    end

    if (ctl.init) begin
      slot_d = lo_q;
      i_d    = lo_q + IW'(1);
    end
    if (ctl.piv_ld)   pivot_d = rd_a_q;
    if (ctl.slot_inc) slot_d  = slot_nxt;
    if (ctl.i_inc)    i_d     = i_q + IW'(1);
    if (ctl.narrow) begin
      if (slot_q > tgt_q) begin
        hi_d = slot_q - IW'(1);
      end else begin
        lo_d = slot_nxt;
      end
    end
    // pivot settles at slot: it is the answer when the round lands on the rank
    if (ctl.res && cond_hit) begin
      done_d = 1'b1;
      res_d  = pivot_q;
    end
  end

  // memory port selection: loads own the write port while idle
  always_comb begin
    raddr_a = (ctl.rda_sel == kthsel_pkg::RDA_I) ? i_q[AW-1:0] : lo_q[AW-1:0];
    raddr_b = (ctl.rdb_sel == kthsel_pkg::RDB_SLOT) ? slot_q[AW-1:0] : slot_nxt[AW-1:0];
    we      = 1'b0;
    waddr   = eff_cnt[AW-1:0];
    wdata   = value_i;
    if (step_q == kthsel_pkg::S_IDLE) begin
      we = is_load && room;
    end else begin
      we = ctl.wr_en;
      case (ctl.wa_sel)
        kthsel_pkg::WA_SLOT_NXT: waddr = slot_nxt[AW-1:0];
        kthsel_pkg::WA_I:        waddr = i_q[AW-1:0];
        kthsel_pkg::WA_LO:       waddr = lo_q[AW-1:0];
        kthsel_pkg::WA_SLOT:     waddr = slot_q[AW-1:0];
        default:                 waddr = slot_q[AW-1:0];
      endcase
      case (ctl.wd_sel)
        kthsel_pkg::WD_RD_A:  wdata = rd_a_q;
        kthsel_pkg::WD_RD_B:  wdata = rd_b_q;
        kthsel_pkg::WD_PIVOT: wdata = pivot_q;
        default:              wdata = pivot_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (ctl.rd_en) begin
      rd_a_q <= mem_q[raddr_a];
      rd_b_q <= mem_q[raddr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= kthsel_pkg::S_IDLE;
      count_q   <= '0;
      restart_q <= 1'b0;
      done_o    <= 1'b0;
    end else begin
      step_q    <= step_d;
      count_q   <= count_d;
      restart_q <= restart_d;
      done_o    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q             <= lo_d;
    hi_q             <= hi_d;
    tgt_q            <= tgt_d;
    slot_q           <= slot_d;
    i_q              <= i_d;
    pivot_q          <= pivot_d;
    selected_value_o <= res_d;
    range_error_o    <= err_d;
  end

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && range_error_o) |-> (selected_value_o == '0))
    else $error("range error result carries a nonzero value");

  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_load |=> !busy)
    else $error("load request started the sequencer");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == kthsel_pkg::S_SCAN_RD) |-> ((slot_q < i_q) && (i_q <= hi_q)))
    else $error("scan index outside the partition window");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ELEMENTS))
    else $error("load count beyond store depth");

  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((step_q == kthsel_pkg::S_FIN_B) && found) |=> (done_o && !range_error_o && !busy))
    else $error("finished selection did not deliver its result");
`endif

endmodule
